[src/dcm_pkg.sv]
// Shared types, constants and helpers for the DC motor electro-thermal step block.
// Holds the micro-step table that the controller walks and the saturation helpers.
// Depends on nothing; compiled first.
package dcm_pkg;

  localparam int unsigned FRACTION_BITS_DEF = 16;

  // Intermediates are signed 48-bit values saturated at +-(2^47 - 1).
  localparam int unsigned MAG_W = 47;
  localparam int unsigned VAL_W = 48;
  localparam logic [MAG_W-1:0] CAP_MAG = '1;
  localparam logic signed [VAL_W-1:0] CAP_POS = {1'b0, CAP_MAG};
  localparam logic signed [VAL_W-1:0] CAP_NEG = -CAP_POS;
  localparam logic signed [VAL_W:0] CAP_EXT = {2'b00, CAP_MAG};

  localparam int unsigned SH_W = 7;

  localparam int unsigned DUTY_W = 16;
  localparam int unsigned SPEED_W = 32;
  localparam int unsigned DT_W = 17;
  localparam int unsigned MN_W = 4;
  localparam int unsigned OUT_W = 32;
  localparam int unsigned KEL_W = 26;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned BAT_W = 23;
  localparam int unsigned KV_W = 30;
  localparam int unsigned R0_W = 20;
  localparam int unsigned I0_W = 22;
  localparam int unsigned RTH_W = 23;
  localparam int unsigned CTH_W = 26;
  localparam int unsigned AMB_W = 24;
  localparam int unsigned TEMP_W = 32;

  // Binary fractions with 32 fraction bits: 0.00393 and 60 / (2 pi).
  localparam logic signed [VAL_W-1:0] ALPHA_Q32 = 48'sd16879221;
  localparam logic signed [VAL_W-1:0] RPM_PER_RADS_Q32 = 48'sd41013916535;

  localparam logic signed [VAL_W-1:0] MAX32 = 48'sd2147483647;
  localparam logic signed [VAL_W-1:0] MIN32 = -48'sd2147483648;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BAT  = 3'd0,
    CFG_KV   = 3'd1,
    CFG_R0   = 3'd2,
    CFG_I0   = 3'd3,
    CFG_RTH  = 3'd4,
    CFG_CTH  = 3'd5,
    CFG_AMB  = 3'd6,
    CFG_MN   = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_NET,
    OP_ABS,
    OP_MUL,
    OP_DIV
  } op_e;

  typedef enum logic [1:0] {
    SH_15,
    SH_32,
    SH_FB
  } sh_e;

  typedef enum logic [4:0] {
    R_BAT, R_KV, R_R0, R_I0, R_RTH, R_CTH, R_AMB, R_TEMP,
    R_DUTY, R_SPEED, R_DT, R_ONE, R_ALPHA, R_RPMC,
    R_VOLT, R_RPM, R_BEMF, R_RISE, R_RES, R_CUR, R_TORQ, R_T1, R_T2
  } reg_e;

  localparam int unsigned NUM_REG = 23;

  typedef struct packed {
    op_e  op;
    reg_e src_a;
    reg_e src_b;
    sh_e  sh;
    reg_e dst;
  } cmd_t;

  typedef struct packed {
    logic load_in;
    logic start;
    logic commit;
  } ctl_t;

  typedef struct packed {
    logic done;
    logic out_free;
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_COMMIT
  } state_e;

  localparam int unsigned STEP_W = 5;
  localparam logic [STEP_W-1:0] LAST_STEP = 5'd22;

  function automatic logic signed [VAL_W-1:0] sat48(input logic signed [VAL_W:0] x);
    logic signed [VAL_W-1:0] r;
    if (x > CAP_EXT) begin
      r = CAP_POS;
    end else if (x < -CAP_EXT) begin
      r = CAP_NEG;
    end else begin
      r = x[VAL_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp32(input logic signed [VAL_W-1:0] x);
    logic signed [OUT_W-1:0] r;
    if (x > MAX32) begin
      r = MAX32[OUT_W-1:0];
    end else if (x < MIN32) begin
      r = MIN32[OUT_W-1:0];
    end else begin
      r = x[OUT_W-1:0];
    end
    return r;
  endfunction

  // One tick as a list of operations on named registers.
  function automatic cmd_t step_cmd(input logic [STEP_W-1:0] s);
    cmd_t c;
    unique case (s)
      5'd0:    c = '{OP_MUL, R_BAT,   R_DUTY,  SH_15, R_VOLT};
      5'd1:    c = '{OP_MUL, R_SPEED, R_RPMC,  SH_32, R_RPM};
      5'd2:    c = '{OP_DIV, R_RPM,   R_KV,    SH_FB, R_BEMF};
      5'd3:    c = '{OP_SUB, R_TEMP,  R_AMB,   SH_FB, R_RISE};
      5'd4:    c = '{OP_MUL, R_RISE,  R_ALPHA, SH_32, R_T1};
      5'd5:    c = '{OP_ADD, R_ONE,   R_T1,    SH_FB, R_T1};
      5'd6:    c = '{OP_MUL, R_R0,    R_T1,    SH_FB, R_RES};
      5'd7:    c = '{OP_SUB, R_VOLT,  R_BEMF,  SH_FB, R_T1};
      5'd8:    c = '{OP_DIV, R_T1,    R_RES,   SH_FB, R_CUR};
      5'd9:    c = '{OP_NET, R_CUR,   R_I0,    SH_FB, R_T1};
      5'd10:   c = '{OP_MUL, R_T1,    R_RPMC,  SH_32, R_T1};
      5'd11:   c = '{OP_DIV, R_T1,    R_KV,    SH_FB, R_TORQ};
      5'd12:   c = '{OP_MUL, R_CUR,   R_CUR,   SH_FB, R_T1};
      5'd13:   c = '{OP_MUL, R_T1,    R_RES,   SH_FB, R_T1};
      5'd14:   c = '{OP_ABS, R_BEMF,  R_BEMF,  SH_FB, R_T2};
      5'd15:   c = '{OP_MUL, R_I0,    R_T2,    SH_FB, R_T2};
      5'd16:   c = '{OP_ADD, R_T1,    R_T2,    SH_FB, R_T1};
      5'd17:   c = '{OP_DIV, R_T1,    R_CTH,   SH_FB, R_T1};
      5'd18:   c = '{OP_MUL, R_RTH,   R_CTH,   SH_FB, R_T2};
      5'd19:   c = '{OP_DIV, R_RISE,  R_T2,    SH_FB, R_T2};
      5'd20:   c = '{OP_SUB, R_T1,    R_T2,    SH_FB, R_T1};
      5'd21:   c = '{OP_MUL, R_T1,    R_DT,    SH_FB, R_T1};
      5'd22:   c = '{OP_ADD, R_TEMP,  R_T1,    SH_FB, R_T1};
      default: c = '{OP_ADD, R_T1,    R_T2,    SH_FB, R_T1};
    endcase
    return c;
  endfunction

endpackage

[src/dcm_if.sv]
// Handshake channels of the motor step block: input items, result items, register writes.
// Depends on dcm_pkg for the field widths.
interface dcm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [dcm_pkg::DUTY_W-1:0]    duty;
  logic signed [dcm_pkg::SPEED_W-1:0]   joint_speed;
  logic [dcm_pkg::DT_W-1:0]             tick_length;

  modport source (output valid, duty, joint_speed, tick_length, input ready);
  modport sink (input valid, duty, joint_speed, tick_length, output ready);
endinterface

interface dcm_out_if;
  logic                               valid;
  logic                               ready;
  logic [dcm_pkg::MN_W-1:0]           motor_number_out;
  logic signed [dcm_pkg::OUT_W-1:0]   speed_rpm;
  logic signed [dcm_pkg::OUT_W-1:0]   terminal_voltage;
  logic signed [dcm_pkg::OUT_W-1:0]   motor_current;
  logic signed [dcm_pkg::OUT_W-1:0]   torque;
  logic [dcm_pkg::KEL_W-1:0]          temperature_kelvin;

  modport source (output valid, motor_number_out, speed_rpm, terminal_voltage,
                  motor_current, torque, temperature_kelvin, input ready);
  modport sink (input valid, motor_number_out, speed_rpm, terminal_voltage,
                motor_current, torque, temperature_kelvin, output ready);
endinterface

interface dcm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [dcm_pkg::CFG_IDX_W-1:0]     index;
  logic [dcm_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[src/dcm_muldiv.sv]
// Shared iterative unit: unsigned shift-add multiplier and restoring divider.
// Works on magnitudes, saturates the result at 2^47 - 1. Depends on dcm_pkg.
module dcm_muldiv #(
  parameter int unsigned FRACTION_BITS = dcm_pkg::FRACTION_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        is_div_i,
  input  logic [dcm_pkg::MAG_W-1:0]   a_i,
  input  logic [dcm_pkg::MAG_W-1:0]   b_i,
  input  logic [dcm_pkg::SH_W-1:0]    sh_i,
  output logic                        done_o,
  output logic [dcm_pkg::MAG_W-1:0]   mag_o
);
  import dcm_pkg::*;

  localparam int unsigned DW = MAG_W + FRACTION_BITS;
  localparam int unsigned PW = 2 * MAG_W;
  localparam int unsigned CW = $clog2(DW);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic          div_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [MAG_W-1:0] b_q;
  logic [MAG_W-1:0] a_q;
  logic [PW-1:0]    p_q;
  logic [MAG_W-1:0] r_q;
  logic [DW-1:0]    q_q;
  logic [SH_W-1:0]  sh_q;

  logic [MAG_W:0]   sum;
  logic [MAG_W:0]   r_sh;
  logic [MAG_W+1:0] diff;
  logic             ge;
  logic [CW-1:0]    last;
  logic [PW-1:0]    p_sh;

  always_comb begin
    sum  = {1'b0, p_q[PW-1:MAG_W]} + (p_q[0] ? {1'b0, a_q} : '0);
    r_sh = {r_q, q_q[DW-1]};
    diff = {1'b0, r_sh} - {2'b00, b_q};
    ge   = !diff[MAG_W+1];
    last = div_q ? CW'(DW - 1) : CW'(MAG_W - 1);
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      if (cnt_q == last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= is_div_i;
      a_q   <= a_i;
      b_q   <= b_i;
      sh_q  <= sh_i;
      p_q   <= {{MAG_W{1'b0}}, b_i};
      r_q   <= '0;
      q_q   <= {a_i, {FRACTION_BITS{1'b0}}};
    end else if (busy_q) begin
      if (div_q) begin
        r_q <= ge ? diff[MAG_W-1:0] : r_sh[MAG_W-1:0];
        q_q <= {q_q[DW-2:0], ge};
      end else begin
        p_q <= {sum, p_q[MAG_W-1:1]};
      end
    end
  end

  // Anything left above bit 46 after the shift means the magnitude saturates.
  always_comb begin
    p_sh = p_q >> sh_q;
    if (div_q) begin
      mag_o = (|q_q[DW-1:MAG_W]) ? CAP_MAG : q_q[MAG_W-1:0];
    end else begin
      mag_o = (|p_sh[PW-1:MAG_W]) ? CAP_MAG : p_sh[MAG_W-1:0];
    end
  end

  assign done_o = done_q;

endmodule

[src/dcm_dpath.sv]
// Datapath: configuration registers, temperature state, operand registers, the
// combinational ALU, the shared multiply/divide unit and the result register.
// Depends on dcm_pkg and dcm_muldiv.
module dcm_dpath #(
  parameter int unsigned FRACTION_BITS = dcm_pkg::FRACTION_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  dcm_pkg::cmd_t                      cmd_i,
  input  dcm_pkg::ctl_t                      ctl_i,
  output dcm_pkg::status_t                   status_o,
  input  logic signed [dcm_pkg::DUTY_W-1:0]  duty_i,
  input  logic signed [dcm_pkg::SPEED_W-1:0] joint_speed_i,
  input  logic [dcm_pkg::DT_W-1:0]           tick_length_i,
  input  logic                               cfg_we_i,
  input  logic [dcm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dcm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [dcm_pkg::MN_W-1:0]           motor_number_out_o,
  output logic signed [dcm_pkg::OUT_W-1:0]   speed_rpm_o,
  output logic signed [dcm_pkg::OUT_W-1:0]   terminal_voltage_o,
  output logic signed [dcm_pkg::OUT_W-1:0]   motor_current_o,
  output logic signed [dcm_pkg::OUT_W-1:0]   torque_o,
  output logic [dcm_pkg::KEL_W-1:0]          temperature_kelvin_o
);
  import dcm_pkg::*;

  localparam logic [63:0] ONE64 = 64'd1 << FRACTION_BITS;
  localparam logic [63:0] BAT_RST = (64'd168 * ONE64 + 64'd5) / 64'd10;
  localparam logic [63:0] KV_RST = 64'd920 * ONE64;
  localparam logic [63:0] R0_RST = (64'd115 * ONE64 + 64'd500) / 64'd1000;
  localparam logic [63:0] I0_RST = (64'd5 * ONE64 + 64'd5) / 64'd10;
  localparam logic [63:0] RTH_RST = (64'd14 * ONE64 + 64'd5) / 64'd10;
  localparam logic [63:0] CTH_RST = (64'd21428 * ONE64 + 64'd50) / 64'd100;
  localparam logic [63:0] AMB_RST = 64'd25 * ONE64;
  localparam logic [63:0] KOFF64 = (64'd27315 * ONE64 + 64'd50) / 64'd100;
  localparam logic [63:0] TMAX64 = 64'd1000 * ONE64;
  localparam logic signed [VAL_W-1:0] ONE_Q = ONE64[VAL_W-1:0];
  localparam logic signed [VAL_W-1:0] KOFF = KOFF64[VAL_W-1:0];
  localparam logic signed [VAL_W-1:0] TMAX = TMAX64[VAL_W-1:0];

  logic [BAT_W-1:0]          bat_q;
  logic [KV_W-1:0]           kv_q;
  logic [R0_W-1:0]           r0_q;
  logic [I0_W-1:0]           i0_q;
  logic [RTH_W-1:0]          rth_q;
  logic [CTH_W-1:0]          cth_q;
  logic signed [AMB_W-1:0]   amb_q;
  logic [MN_W-1:0]           mn_q;
  logic signed [TEMP_W-1:0]  temp_q;

  logic signed [DUTY_W-1:0]  duty_q;
  logic signed [SPEED_W-1:0] speed_q;
  logic [DT_W-1:0]           dt_q;

  logic signed [VAL_W-1:0] volt_q, rpm_q, bemf_q, rise_q, res_q, cur_q, torq_q, t1_q, t2_q;
  logic                    ten_q;
  logic                    out_valid_q;

  logic signed [VAL_W-1:0] src [NUM_REG];
  logic signed [VAL_W-1:0] op_a, op_b, a_abs, b_abs, wb;
  logic [SH_W-1:0]         sh_amt;
  logic                    single, we, md_done;
  logic [MAG_W-1:0]        md_mag, mag_eff;
  logic                    neg;
  logic signed [VAL_W-1:0] t_cl, kel;
  logic signed [TEMP_W-1:0] temp_next;

  always_comb begin
    src[R_BAT]   = VAL_W'(bat_q);
    src[R_KV]    = VAL_W'(kv_q);
    src[R_R0]    = VAL_W'(r0_q);
    src[R_I0]    = VAL_W'(i0_q);
    src[R_RTH]   = VAL_W'(rth_q);
    src[R_CTH]   = VAL_W'(cth_q);
    src[R_AMB]   = VAL_W'(amb_q);
    src[R_TEMP]  = VAL_W'(temp_q);
    src[R_DUTY]  = VAL_W'(duty_q);
    src[R_SPEED] = VAL_W'(speed_q);
    src[R_DT]    = VAL_W'(dt_q);
    src[R_ONE]   = ONE_Q;
    src[R_ALPHA] = ALPHA_Q32;
    src[R_RPMC]  = RPM_PER_RADS_Q32;
    src[R_VOLT]  = volt_q;
    src[R_RPM]   = rpm_q;
    src[R_BEMF]  = bemf_q;
    src[R_RISE]  = rise_q;
    src[R_RES]   = res_q;
    src[R_CUR]   = cur_q;
    src[R_TORQ]  = torq_q;
    src[R_T1]    = t1_q;
    src[R_T2]    = t2_q;
  end

  assign op_a = src[cmd_i.src_a];
  assign op_b = src[cmd_i.src_b];
  assign a_abs = op_a[VAL_W-1] ? -op_a : op_a;
  assign b_abs = op_b[VAL_W-1] ? -op_b : op_b;
  assign single = (cmd_i.op != OP_MUL) && (cmd_i.op != OP_DIV);

  always_comb begin
    unique case (cmd_i.sh)
      SH_15:   sh_amt = SH_W'(15);
      SH_32:   sh_amt = SH_W'(32);
      SH_FB:   sh_amt = SH_W'(FRACTION_BITS);
      default: sh_amt = SH_W'(FRACTION_BITS);
    endcase
  end

  dcm_muldiv #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl_i.start && !single),
    .is_div_i(cmd_i.op == OP_DIV),
    .a_i     (a_abs[MAG_W-1:0]),
    .b_i     (b_abs[MAG_W-1:0]),
    .sh_i    (sh_amt),
    .done_o  (md_done),
    .mag_o   (md_mag)
  );

  // A zero divisor gives full scale with the sign of the dividend, or zero.
  always_comb begin
    neg = op_a[VAL_W-1] ^ op_b[VAL_W-1];
    if (cmd_i.op == OP_DIV && op_b == '0) begin
      mag_eff = (op_a == '0) ? '0 : CAP_MAG;
    end else begin
      mag_eff = md_mag;
    end
    unique case (cmd_i.op)
      OP_ADD:  wb = sat48({op_a[VAL_W-1], op_a} + {op_b[VAL_W-1], op_b});
      OP_SUB:  wb = sat48({op_a[VAL_W-1], op_a} - {op_b[VAL_W-1], op_b});
      OP_NET: begin
        if (op_a > 0) begin
          wb = sat48({op_a[VAL_W-1], op_a} - {op_b[VAL_W-1], op_b});
        end else begin
          wb = sat48({op_a[VAL_W-1], op_a} + {op_b[VAL_W-1], op_b});
        end
      end
      OP_ABS:  wb = a_abs;
      OP_MUL, OP_DIV: wb = neg ? -$signed({1'b0, mag_eff}) : $signed({1'b0, mag_eff});
      default: wb = op_a;
    endcase
    we = (ctl_i.start && single) || md_done;
  end

  always_comb begin
    t_cl = (t1_q < src[R_AMB]) ? src[R_AMB] : t1_q;
    temp_next = clamp32(t_cl);
    kel = VAL_W'(temp_next) + KOFF;
    if (kel < 0) begin
      kel = '0;
    end else if (kel > TMAX) begin
      kel = TMAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_in) begin
      duty_q  <= duty_i;
      speed_q <= joint_speed_i;
      dt_q    <= tick_length_i;
    end
    if (we) begin
      unique case (cmd_i.dst)
        R_VOLT:  volt_q <= wb;
        R_RPM:   rpm_q  <= wb;
        R_BEMF:  bemf_q <= wb;
        R_RISE:  rise_q <= wb;
        R_RES:   res_q  <= wb;
        R_CUR:   cur_q  <= wb;
        R_TORQ:  torq_q <= wb;
        R_T1:    t1_q   <= wb;
        R_T2:    t2_q   <= wb;
        default: ;
      endcase
      if (cmd_i.op == OP_NET) begin
        ten_q <= a_abs > op_b;
      end
    end
    if (ctl_i.commit) begin
      motor_number_out_o   <= mn_q;
      speed_rpm_o          <= clamp32(rpm_q);
      terminal_voltage_o   <= clamp32(volt_q);
      motor_current_o      <= clamp32(cur_q);
      torque_o             <= ten_q ? clamp32(torq_q) : '0;
      temperature_kelvin_o <= kel[KEL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bat_q       <= BAT_RST[BAT_W-1:0];
      kv_q        <= KV_RST[KV_W-1:0];
      r0_q        <= R0_RST[R0_W-1:0];
      i0_q        <= I0_RST[I0_W-1:0];
      rth_q       <= RTH_RST[RTH_W-1:0];
      cth_q       <= CTH_RST[CTH_W-1:0];
      amb_q       <= AMB_RST[AMB_W-1:0];
      mn_q        <= '0;
      temp_q      <= TEMP_W'($signed(AMB_RST[AMB_W-1:0]));
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_BAT: bat_q <= cfg_data_i[BAT_W-1:0];
          CFG_KV:  kv_q  <= cfg_data_i[KV_W-1:0];
          CFG_R0:  r0_q  <= cfg_data_i[R0_W-1:0];
          CFG_I0:  i0_q  <= cfg_data_i[I0_W-1:0];
          CFG_RTH: rth_q <= cfg_data_i[RTH_W-1:0];
          CFG_CTH: cth_q <= cfg_data_i[CTH_W-1:0];
          CFG_AMB: begin
            amb_q  <= cfg_data_i[AMB_W-1:0];
            temp_q <= TEMP_W'($signed(cfg_data_i[AMB_W-1:0]));
          end
          CFG_MN:  mn_q  <= cfg_data_i[MN_W-1:0];
          default: ;
        endcase
      end
      if (ctl_i.commit) begin
        temp_q      <= temp_next;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.done     = md_done;
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule

[src/dcm_ctrl.sv]
// Controller: takes an input beat, walks the operation list one step at a time,
// waits on the multiply/divide unit and commits the result. Depends on dcm_pkg.
module dcm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dcm_pkg::status_t   status_i,
  output dcm_pkg::cmd_t      cmd_o,
  output dcm_pkg::ctl_t      ctl_o
);
  import dcm_pkg::*;

  state_e              state_q, state_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic                single;

  assign cmd_o  = step_cmd(step_q);
  assign single = (cmd_o.op != OP_MUL) && (cmd_o.op != OP_DIV);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load_in = 1'b1;
          step_d        = '0;
          state_d       = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        ctl_o.start = 1'b1;
        if (!single) begin
          state_d = ST_WAIT;
        end else if (step_q == LAST_STEP) begin
          state_d = ST_COMMIT;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_WAIT: begin
        if (status_i.done) begin
          if (step_q == LAST_STEP) begin
            state_d = ST_COMMIT;
          end else begin
            step_d  = step_q + 1'b1;
            state_d = ST_ISSUE;
          end
        end
      end
      ST_COMMIT: begin
        if (status_i.out_free) begin
          ctl_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[src/dc_motor_electro_thermal_step.sv]
// Top level of the DC motor electro-thermal step block.
// Depends on dcm_pkg, dcm_if, dcm_ctrl and dcm_dpath (which holds dcm_muldiv).

// One input beat is one simulation tick; it yields exactly one result beat. Ticks are
// handled one at a time: a new tick is taken only once the last one is committed to the
// result register. Most of the work falls on the single shared multiply/divide unit,
// which runs ten multiplies and five divides; the other eight steps are single-step
// arithmetic, and a commit step follows.
// The next tick is taken while the previous result still waits on the output. Register
// writes are always ready; writing the ambient temperature also resets the motor
// temperature to it, and after reset the motor temperature equals the 25 C ambient.
module dc_motor_electro_thermal_step #(
  parameter int unsigned FRACTION_BITS = dcm_pkg::FRACTION_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dcm_in_if.sink        in_ch,
  dcm_out_if.source     out_ch,
  dcm_cfg_if.sink       cfg_ch
);
  import dcm_pkg::*;

  cmd_t    cmd;
  ctl_t    ctl;
  status_t status;

  assign cfg_ch.ready = 1'b1;

  dcm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_ch.valid),
    .in_ready_o(in_ch.ready),
    .status_i  (status),
    .cmd_o     (cmd),
    .ctl_o     (ctl)
  );

  dcm_dpath #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .ctl_i               (ctl),
    .status_o            (status),
    .duty_i              (in_ch.duty),
    .joint_speed_i       (in_ch.joint_speed),
    .tick_length_i       (in_ch.tick_length),
    .cfg_we_i            (cfg_ch.valid),
    .cfg_index_i         (cfg_ch.index),
    .cfg_data_i          (cfg_ch.data),
    .out_valid_o         (out_ch.valid),
    .out_ready_i         (out_ch.ready),
    .motor_number_out_o  (out_ch.motor_number_out),
    .speed_rpm_o         (out_ch.speed_rpm),
    .terminal_voltage_o  (out_ch.terminal_voltage),
    .motor_current_o     (out_ch.motor_current),
    .torque_o            (out_ch.torque),
    .temperature_kelvin_o(out_ch.temperature_kelvin)
  );

  // A result is committed only into a free output slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.commit |-> (!out_ch.valid || out_ch.ready))
    else $error("result committed over a pending beat");

  // Once a tick is taken, no further input beat is taken until it is done.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken while a tick is in flight");

  // A result beat only appears after a commit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_ch.valid) |-> $past(ctl.commit))
    else $error("result valid without a commit");

endmodule
